@@ hdl/csrc_pkg.sv @@
package csrc_pkg;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT      = 3'd0,
    VERDICT_BAD_ID      = 3'd1,
    VERDICT_BAD_DLC     = 3'd2,
    VERDICT_STALE       = 3'd3,
    VERDICT_RANGE       = 3'd4,
    VERDICT_TICK_QUIET  = 3'd5,
    VERDICT_TIMEOUT     = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    REG_EXPECTED_ID   = 2'd0,
    REG_EXPECTED_DLC  = 2'd1,
    REG_MAX_SPEED     = 2'd2,
    REG_TIMEOUT_LIMIT = 2'd3
  } reg_idx_e;

  localparam logic [10:0] EXPECTED_ID_RST   = 11'd0;
  localparam logic [3:0]  EXPECTED_DLC_RST  = 4'd3;
  localparam logic [15:0] MAX_SPEED_RST     = 16'hFFFF;
  localparam logic [31:0] TIMEOUT_LIMIT_RST = 32'd500;

  localparam logic [7:0]  STALE_WINDOW = 8'd128;

  typedef struct packed {
    logic [10:0] expected_id;
    logic [3:0]  expected_dlc;
    logic [15:0] max_speed;
    logic [31:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic        is_tick;
    logic        bad_id;
    logic        bad_dlc;
    logic        over_range;
    logic [15:0] speed;
    logic [7:0]  alive;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [31:0] accepted;
    logic [31:0] bad_id;
    logic [31:0] bad_dlc;
    logic [31:0] stale;
    logic [31:0] range;
    logic [31:0] timeout;
  } counts_t;

endpackage

@@ hdl/csrc_front.sv @@
module csrc_front (
  input  logic             command_i,
  input  logic [10:0]      can_id_i,
  input  logic [3:0]       frame_dlc_i,
  input  logic [7:0]       speed_low_i,
  input  logic [7:0]       speed_high_i,
  input  logic [7:0]       alive_counter_i,
  input  logic [31:0]      time_ms_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csrc_pkg::cfg_t   cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output csrc_pkg::item_t  item_o
);
  import csrc_pkg::*;

  logic [15:0] speed;

  assign speed      = {speed_high_i, speed_low_i};
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // The checks that depend only on the word and the configuration are made here.
  always_comb begin
    item_o.is_tick    = command_i;
    item_o.bad_id     = (can_id_i != cfg_i.expected_id);
    item_o.bad_dlc    = (frame_dlc_i != cfg_i.expected_dlc);
    item_o.over_range = (speed > cfg_i.max_speed);
    item_o.speed      = speed;
    item_o.alive      = alive_counter_i;
    item_o.time_ms    = time_ms_i;
  end

endmodule

@@ hdl/csrc_queue.sv @@
module csrc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csrc_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output csrc_pkg::item_t  item_o
);
  import csrc_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/csrc_back.sv @@
module csrc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        timeout_limit_i,
  input  logic               q_valid_i,
  input  csrc_pkg::item_t    q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csrc_pkg::verdict_e verdict_o,
  output logic [15:0]        speed_o,
  output logic [7:0]         counter_o,
  output logic               timed_out_o,
  output csrc_pkg::counts_t  counts_o
);
  import csrc_pkg::*;

  logic        out_valid_q, out_valid_d;
  verdict_e    verdict_q, verdict_d;
  logic [15:0] speed_q, speed_d;
  logic [7:0]  counter_q, counter_d;
  logic [31:0] last_rx_q, last_rx_d;
  logic        seen_q, seen_d;
  logic        timeout_q, timeout_d;
  counts_t     counts_q, counts_d;
  logic [7:0]  diff;
  logic        fresh;
  logic [31:0] age;

  // The state only moves when a word is popped, which happens only once the
  // previous result has been taken, so the state registers double as outputs.
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign diff  = q_item_i.alive - counter_q;
  assign fresh = (diff != 8'd0) && (diff <= STALE_WINDOW);
  assign age   = q_item_i.time_ms - last_rx_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;
    speed_d     = speed_q;
    counter_d   = counter_q;
    last_rx_d   = last_rx_q;
    seen_d      = seen_q;
    timeout_d   = timeout_q;
    counts_d    = counts_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      if (q_item_i.is_tick) begin
        if (seen_q && !timeout_q && (age >= timeout_limit_i)) begin
          verdict_d        = VERDICT_TIMEOUT;
          timeout_d        = 1'b1;
          counts_d.timeout = counts_q.timeout + 32'd1;
        end else begin
          verdict_d = VERDICT_TICK_QUIET;
        end
      end else if (q_item_i.bad_id) begin
        verdict_d       = VERDICT_BAD_ID;
        counts_d.bad_id = counts_q.bad_id + 32'd1;
      end else if (q_item_i.bad_dlc) begin
        verdict_d        = VERDICT_BAD_DLC;
        counts_d.bad_dlc = counts_q.bad_dlc + 32'd1;
      end else if (seen_q && !fresh) begin
        verdict_d      = VERDICT_STALE;
        counts_d.stale = counts_q.stale + 32'd1;
      end else if (q_item_i.over_range) begin
        verdict_d      = VERDICT_RANGE;
        counts_d.range = counts_q.range + 32'd1;
      end else begin
        verdict_d         = VERDICT_ACCEPT;
        speed_d           = q_item_i.speed;
        counter_d         = q_item_i.alive;
        last_rx_d         = q_item_i.time_ms;
        seen_d            = 1'b1;
        timeout_d         = 1'b0;
        counts_d.accepted = counts_q.accepted + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_ACCEPT;
      speed_q     <= 16'd0;
      counter_q   <= 8'd0;
      last_rx_q   <= 32'd0;
      seen_q      <= 1'b0;
      timeout_q   <= 1'b0;
      counts_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
      speed_q     <= speed_d;
      counter_q   <= counter_d;
      last_rx_q   <= last_rx_d;
      seen_q      <= seen_d;
      timeout_q   <= timeout_d;
      counts_q    <= counts_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign speed_o     = speed_q;
  assign counter_o   = counter_q;
  assign timed_out_o = timeout_q;
  assign counts_o    = counts_q;

endmodule

@@ hdl/can_signal_receive_checker.sv @@
// Accepted words are queued; the checking stage pops each and registers its result.
// Throughput: one word per cycle while the queue has room and no result is stalled.
// A two-entry queue sits between the input checks and the state update stage.
// Reset is asynchronous and active low; it clears all state, counters and the queue,
// and loads the register defaults. No clearing pass follows reset.
module can_signal_receive_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [10:0] can_id_i,
  input  logic [3:0]  frame_dlc_i,
  input  logic [7:0]  speed_low_i,
  input  logic [7:0]  speed_high_i,
  input  logic [7:0]  alive_counter_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [15:0] current_speed_o,
  output logic [7:0]  last_counter_o,
  output logic        timed_out_o,
  output logic [31:0] accepted_total_o,
  output logic [31:0] bad_id_total_o,
  output logic [31:0] bad_dlc_total_o,
  output logic [31:0] stale_total_o,
  output logic [31:0] range_total_o,
  output logic [31:0] timeout_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csrc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_write;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  item_t    front_item;
  item_t    q_item;
  verdict_e verdict;
  counts_t  counts;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_EXPECTED_ID:   cfg_d.expected_id   = pwdata[10:0];
        REG_EXPECTED_DLC:  cfg_d.expected_dlc  = pwdata[3:0];
        REG_MAX_SPEED:     cfg_d.max_speed     = pwdata[15:0];
        REG_TIMEOUT_LIMIT: cfg_d.timeout_limit = pwdata;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXPECTED_ID:   prdata = {21'd0, cfg_q.expected_id};
      REG_EXPECTED_DLC:  prdata = {28'd0, cfg_q.expected_dlc};
      REG_MAX_SPEED:     prdata = {16'd0, cfg_q.max_speed};
      REG_TIMEOUT_LIMIT: prdata = cfg_q.timeout_limit;
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id   <= EXPECTED_ID_RST;
      cfg_q.expected_dlc  <= EXPECTED_DLC_RST;
      cfg_q.max_speed     <= MAX_SPEED_RST;
      cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  csrc_front u_front (
    .command_i       (command_i),
    .can_id_i        (can_id_i),
    .frame_dlc_i     (frame_dlc_i),
    .speed_low_i     (speed_low_i),
    .speed_high_i    (speed_high_i),
    .alive_counter_i (alive_counter_i),
    .time_ms_i       (time_ms_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (front_item)
  );

  csrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  csrc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timeout_limit_i (cfg_q.timeout_limit),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .verdict_o       (verdict),
    .speed_o         (current_speed_o),
    .counter_o       (last_counter_o),
    .timed_out_o     (timed_out_o),
    .counts_o        (counts)
  );

  assign verdict_o        = verdict;
  assign accepted_total_o = counts.accepted;
  assign bad_id_total_o   = counts.bad_id;
  assign bad_dlc_total_o  = counts.bad_dlc;
  assign stale_total_o    = counts.stale;
  assign range_total_o    = counts.range;
  assign timeout_total_o  = counts.timeout;

endmodule

@@ hdl/csrc_checker.sv @@
module csrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  verdict_o,
  input logic        timed_out_o,
  input logic [31:0] accepted_total_o,
  input logic [31:0] bad_id_total_o,
  input logic [31:0] timeout_total_o
);
  import csrc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(verdict_o) && $stable(accepted_total_o))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_ACCEPT) |-> !timed_out_o)
    else $error("Accepted frame left the timeout active.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_TIMEOUT) |->
      timed_out_o && (timeout_total_o != 32'd0))
    else $error("Timeout verdict without active timeout.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(accepted_total_o) |-> out_valid_o && (verdict_o == VERDICT_ACCEPT))
    else $error("Accept count moved without an accepted frame.");

endmodule

bind can_signal_receive_checker csrc_checker u_csrc_checker (.*);

@@ tb/sv/can_signal_receive_checker_test.sv @@
`timescale 1ns / 1ps

module can_signal_receive_checker_test;
  import csrc_pkg::*;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [7:0]  speed_low;
    logic [7:0]  speed_high;
    logic [7:0]  alive;
    logic [31:0] time_ms;
  } frame_word_t;

  typedef struct {
    verdict_e    verdict;
    logic [15:0] speed;
    logic [7:0]  counter;
    logic        timed_out;
    counts_t     counts;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = CMD_FRAME;
  logic [10:0] can_id_i = '0;
  logic [3:0]  frame_dlc_i = '0;
  logic [7:0]  speed_low_i = '0;
  logic [7:0]  speed_high_i = '0;
  logic [7:0]  alive_counter_i = '0;
  logic [31:0] time_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [15:0] current_speed_o;
  logic [7:0]  last_counter_o;
  logic        timed_out_o;
  logic [31:0] accepted_total_o;
  logic [31:0] bad_id_total_o;
  logic [31:0] bad_dlc_total_o;
  logic [31:0] stale_total_o;
  logic [31:0] range_total_o;
  logic [31:0] timeout_total_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  can_signal_receive_checker u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .can_id_i         (can_id_i),
    .frame_dlc_i      (frame_dlc_i),
    .speed_low_i      (speed_low_i),
    .speed_high_i     (speed_high_i),
    .alive_counter_i  (alive_counter_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .current_speed_o  (current_speed_o),
    .last_counter_o   (last_counter_o),
    .timed_out_o      (timed_out_o),
    .accepted_total_o (accepted_total_o),
    .bad_id_total_o   (bad_id_total_o),
    .bad_dlc_total_o  (bad_dlc_total_o),
    .stale_total_o    (stale_total_o),
    .range_total_o    (range_total_o),
    .timeout_total_o  (timeout_total_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cfg_t        cfg = '{expected_id: EXPECTED_ID_RST, expected_dlc: EXPECTED_DLC_RST,
                       max_speed: MAX_SPEED_RST, timeout_limit: TIMEOUT_LIMIT_RST};
  logic [15:0] spd_store = '0;
  logic [7:0]  cnt_store = '0;
  logic [31:0] rx_stamp = '0;
  logic        any_accepted = 1'b0;
  logic        tmo_flag = 1'b0;
  counts_t     tally = '0;

  status_t     expected_status[$];
  int unsigned fail_count = 0;
  logic [31:0] now_ms = '0;
  bit          idle_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned stall_left = 0;

  function automatic status_t predict_status(input frame_word_t w);
    status_t     s;
    logic [15:0] spd;
    logic [7:0]  step;
    logic [31:0] age;
    spd  = {w.speed_high, w.speed_low};
    step = w.alive - cnt_store;
    age  = w.time_ms - rx_stamp;
    if (w.command == CMD_TICK) begin
      if (any_accepted && !tmo_flag && age >= cfg.timeout_limit) begin
        tmo_flag      = 1'b1;
        tally.timeout = tally.timeout + 1;
        s.verdict     = VERDICT_TIMEOUT;
      end else begin
        s.verdict = VERDICT_TICK_QUIET;
      end
    end else if (w.can_id != cfg.expected_id) begin
      tally.bad_id = tally.bad_id + 1;
      s.verdict    = VERDICT_BAD_ID;
    end else if (w.dlc != cfg.expected_dlc) begin
      tally.bad_dlc = tally.bad_dlc + 1;
      s.verdict     = VERDICT_BAD_DLC;
    end else if (any_accepted && (step == 8'd0 || step > STALE_WINDOW)) begin
      tally.stale = tally.stale + 1;
      s.verdict   = VERDICT_STALE;
    end else if (spd > cfg.max_speed) begin
      tally.range = tally.range + 1;
      s.verdict   = VERDICT_RANGE;
    end else begin
      spd_store      = spd;
      cnt_store      = w.alive;
      rx_stamp       = w.time_ms;
      any_accepted   = 1'b1;
      tmo_flag       = 1'b0;
      tally.accepted = tally.accepted + 1;
      s.verdict      = VERDICT_ACCEPT;
    end
    s.speed     = spd_store;
    s.counter   = cnt_store;
    s.timed_out = tmo_flag;
    s.counts    = tally;
    return s;
  endfunction

  function automatic frame_word_t make_frame(input logic [10:0] id, input logic [3:0] dlc,
                                             input logic [15:0] spd, input logic [7:0] alive,
                                             input logic [31:0] stamp);
    frame_word_t w;
    w = '{command: CMD_FRAME, can_id: id, dlc: dlc, speed_low: spd[7:0],
          speed_high: spd[15:8], alive: alive, time_ms: stamp};
    return w;
  endfunction

  // Frame fields of a tick carry random junk; the block must ignore them.
  function automatic frame_word_t make_tick(input logic [31:0] stamp);
    frame_word_t w;
    w = '{command: CMD_TICK, can_id: 11'($urandom), dlc: 4'($urandom),
          speed_low: 8'($urandom), speed_high: 8'($urandom), alive: 8'($urandom),
          time_ms: stamp};
    return w;
  endfunction

  function automatic frame_word_t make_random_word();
    frame_word_t w;
    int unsigned pick;
    int unsigned lim;
    pick   = $urandom_range(0, 99);
    lim    = cfg.max_speed;
    now_ms = now_ms + $urandom_range(0, 300);
    w = '{command: 1'($urandom), can_id: 11'($urandom), dlc: 4'($urandom),
          speed_low: 8'($urandom), speed_high: 8'($urandom), alive: 8'($urandom),
          time_ms: $urandom};
    if (pick < 10) begin
      return w;
    end
    if (pick < 35) begin
      return make_tick(now_ms);
    end
    w = make_frame(cfg.expected_id, cfg.expected_dlc, 16'($urandom_range(0, lim)),
                   cnt_store + 8'($urandom_range(1, 128)), now_ms);
    if (pick < 43) begin
      w.can_id = 11'($urandom);
    end else if (pick < 50) begin
      w.dlc = 4'($urandom);
    end else if (pick < 60) begin
      w.alive = cnt_store - 8'($urandom_range(0, 127));
    end else if (pick < 68 && lim < 16'hFFFF) begin
      {w.speed_high, w.speed_low} = 16'($urandom_range(lim + 1, 16'hFFFF));
    end
    return w;
  endfunction

  task automatic send_word(input frame_word_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= w.command;
    can_id_i        <= w.can_id;
    frame_dlc_i     <= w.dlc;
    speed_low_i     <= w.speed_low;
    speed_high_i    <= w.speed_high;
    alive_counter_i <= w.alive;
    time_ms_i       <= w.time_ms;
    do @(posedge clk_i); while (in_stall_o);
    expected_status.push_back(predict_status(w));
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_EXPECTED_ID:   cfg.expected_id   = value[10:0];
      REG_EXPECTED_DLC:  cfg.expected_dlc  = value[3:0];
      REG_MAX_SPEED:     cfg.max_speed     = value[15:0];
      REG_TIMEOUT_LIMIT: cfg.timeout_limit = value;
      default: ;
    endcase
  endtask

  task automatic check_register(input reg_idx_e idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report_mismatch(idx.name(), want, prdata);
    end
  endtask

  task automatic configure(input logic [10:0] id, input logic [3:0] dlc,
                           input logic [15:0] max_spd, input logic [31:0] limit);
    write_register(REG_EXPECTED_ID, 32'(id));
    write_register(REG_EXPECTED_DLC, 32'(dlc));
    write_register(REG_MAX_SPEED, 32'(max_spd));
    write_register(REG_TIMEOUT_LIMIT, limit);
    check_register(REG_EXPECTED_ID, 32'(cfg.expected_id));
    check_register(REG_EXPECTED_DLC, 32'(cfg.expected_dlc));
    check_register(REG_MAX_SPEED, 32'(cfg.max_speed));
    check_register(REG_TIMEOUT_LIMIT, cfg.timeout_limit);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : receiver_pacing
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin : result_check
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        $display("%0t: word with no expected result, verdict %0d", $time, verdict_o);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        if (verdict_o !== want.verdict)
          report_mismatch("verdict", 32'(want.verdict), 32'(verdict_o));
        if (current_speed_o !== want.speed)
          report_mismatch("current_speed", 32'(want.speed), 32'(current_speed_o));
        if (last_counter_o !== want.counter)
          report_mismatch("last_counter", 32'(want.counter), 32'(last_counter_o));
        if (timed_out_o !== want.timed_out)
          report_mismatch("timed_out", 32'(want.timed_out), 32'(timed_out_o));
        if (accepted_total_o !== want.counts.accepted)
          report_mismatch("accepted_total", want.counts.accepted, accepted_total_o);
        if (bad_id_total_o !== want.counts.bad_id)
          report_mismatch("bad_id_total", want.counts.bad_id, bad_id_total_o);
        if (bad_dlc_total_o !== want.counts.bad_dlc)
          report_mismatch("bad_dlc_total", want.counts.bad_dlc, bad_dlc_total_o);
        if (stale_total_o !== want.counts.stale)
          report_mismatch("stale_total", want.counts.stale, stale_total_o);
        if (range_total_o !== want.counts.range)
          report_mismatch("range_total", want.counts.range, range_total_o);
        if (timeout_total_o !== want.counts.timeout)
          report_mismatch("timeout_total", want.counts.timeout, timeout_total_o);
      end
    end
  end

  task automatic test_reset_defaults();
    check_register(REG_EXPECTED_ID, 32'(EXPECTED_ID_RST));
    check_register(REG_EXPECTED_DLC, 32'(EXPECTED_DLC_RST));
    check_register(REG_MAX_SPEED, 32'(MAX_SPEED_RST));
    check_register(REG_TIMEOUT_LIMIT, TIMEOUT_LIMIT_RST);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A tick before the first accepted word stays quiet, and the first accepted
  // word passes with any counter value.
  task automatic test_frame_checks();
    send_word(make_tick(32'd1000));
    send_word(make_frame(11'h7FF, 4'd3, 16'd10, 8'd1, 32'd10));
    send_word(make_frame(11'd0, 4'hF, 16'd10, 8'd1, 32'd20));
    send_word(make_frame(11'd0, 4'd0, 16'd10, 8'd1, 32'd30));
    send_word(make_frame(11'd0, 4'd3, 16'hFFFF, 8'd200, 32'd100));
    send_word(make_frame(11'd0, 4'd3, 16'd5, 8'd200, 32'd110));
    send_word(make_frame(11'd0, 4'd3, 16'd5, 8'd73, 32'd115));
    send_word(make_frame(11'd0, 4'd3, 16'd0, 8'd72, 32'd120));
    send_word(make_frame(11'd0, 4'd3, 16'h1234, 8'd73, 32'd130));
    send_word(make_frame(11'd0, 4'd3, 16'hFF00, 8'd74, 32'd130));
  endtask

  // The age is taken modulo 2^32, so a tick after the time stamp wraps still
  // sees the true distance; a second tick while timed out stays quiet.
  task automatic test_timeout();
    send_word(make_tick(32'd629));
    send_word(make_tick(32'd630));
    send_word(make_tick(32'd5000));
    send_word(make_frame(11'd0, 4'd3, 16'h00FF, 8'd75, 32'hFFFF_FF00));
    send_word(make_tick(32'h0000_00F3));
    send_word(make_tick(32'h0000_00F4));
    send_word(make_frame(11'd1, 4'd3, 16'd1, 8'd76, 32'h0000_0100));
    settle_block();
  endtask

  task automatic test_config_extremes();
    configure(11'h7FF, 4'd8, 16'd0, 32'd0);
    send_word(make_frame(11'h7FF, 4'd8, 16'd1, 8'd76, 32'd7));
    send_word(make_frame(11'h7FF, 4'd8, 16'd0, 8'd76, 32'd8));
    send_word(make_tick(32'd8));
    send_word(make_tick(32'd9));
    send_word(make_frame(11'd0, 4'd3, 16'd0, 8'd77, 32'd10));
    settle_block();
    configure(11'd0, 4'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(make_frame(11'd0, 4'd0, 16'hFFFF, 8'd77, 32'd5));
    send_word(make_tick(32'd3));
    send_word(make_tick(32'd4));
    send_word(make_tick(32'd4));
    settle_block();
  endtask

  task automatic test_backpressure();
    configure(11'h555, 4'd4, 16'd30000, 32'd1000);
    now_ms       = rx_stamp;
    hold_request = 60;
    repeat (16) send_word(make_random_word());
    settle_block();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      configure(11'($urandom), 4'($urandom_range(0, 8)), 16'($urandom),
                32'($urandom_range(0, 1500)));
      idle_on = (phase != 3);
      now_ms  = rx_stamp;
      repeat (95) send_word(make_random_word());
      settle_block();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_frame_checks();
    test_timeout();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/csrc_pkg.sv
hdl/csrc_front.sv
hdl/csrc_queue.sv
hdl/csrc_back.sv
hdl/can_signal_receive_checker.sv
hdl/csrc_checker.sv
tb/sv/can_signal_receive_checker_test.sv
